[rtl/der_integer_sequence_parser_defines.svh]
// ----------------------------------------------------------------------------
// der_integer_sequence_parser_defines
// assertion macros shared by the der sequence parser modules
// ----------------------------------------------------------------------------
`ifndef DER_INTEGER_SEQUENCE_PARSER_DEFINES_SVH
`define DER_INTEGER_SEQUENCE_PARSER_DEFINES_SVH

// same-cycle implication, quiet while in reset
`define DERSP_ASSERT_HOLDS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet while in reset
`define DERSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/dersp_pkg.sv]
// ----------------------------------------------------------------------------
// dersp_pkg
// types and constants of the der sequence-of-integers parser
// ----------------------------------------------------------------------------
package dersp_pkg;

	localparam logic [7:0] TAG_SEQUENCE   = 8'h30;
	localparam logic [7:0] TAG_INTEGER    = 8'h02;
	localparam logic [7:0] LONG_FORM_MASK = 8'h80;

	localparam int QUEUE_DEPTH_DEF = 4;

	typedef enum logic [2:0] {
		PH_SEQ_TAG,
		PH_SEQ_LEN,
		PH_INT_TAG,
		PH_INT_LEN,
		PH_FIRST,
		PH_CONTENT
	} phase_t;

	typedef enum logic [1:0] {
		KIND_CONTENT,
		KIND_EMPTY_INT,
		KIND_EMPTY_SEQ,
		KIND_ERROR
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_LONG_LENGTH,
		ERR_BAD_TOP_TAG,
		ERR_BAD_INNER_TAG,
		ERR_OVERRUN,
		ERR_TRUNCATED
	} err_code_t;

	// classified result, fields not yet cleaned per kind
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  content_byte;
		logic [6:0]  byte_position;
		logic [7:0]  integer_index;
		logic [6:0]  integer_length;
		logic        last_of_integer;
		logic        last_of_sequence;
		err_code_t   error_code;
	} rec_t;

endpackage

[rtl/dersp_front.sv]
// ----------------------------------------------------------------------------
// dersp_front
// accepts buffer bytes, tracks the tlv state and classifies each beat
// ----------------------------------------------------------------------------
`include "der_integer_sequence_parser_defines.svh"

module dersp_front import dersp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_of_buffer,
	input  logic       q_full,
	output logic       push,
	output rec_t       rec
);

	phase_t     phase_q, phase_d;
	logic [6:0] seq_q, seq_d;
	logic [6:0] int_q, int_d;
	logic [6:0] krem_q, krem_d;
	logic [6:0] klen_q, klen_d;
	logic [7:0] cnt_q, cnt_d;
	logic       err_q, err_d;
	logic       accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEQ_TAG;
			seq_q   <= '0;
			int_q   <= '0;
			krem_q  <= '0;
			klen_q  <= '0;
			cnt_q   <= '0;
			err_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			seq_q   <= seq_d;
			int_q   <= int_d;
			krem_q  <= krem_d;
			klen_q  <= klen_d;
			cnt_q   <= cnt_d;
			err_q   <= err_d;
		end
	end

	always_comb begin
		err_code_t  err;
		logic       do_content;
		logic       do_empty;
		logic       finish;
		logic [6:0] krem;

		phase_d    = phase_q;
		seq_d      = seq_q;
		int_d      = int_q;
		krem_d     = krem_q;
		klen_d     = klen_q;
		cnt_d      = cnt_q;
		err_d      = err_q;
		push       = 1'b0;
		rec        = '0;
		err        = ERR_NONE;
		do_content = 1'b0;
		do_empty   = 1'b0;
		finish     = 1'b0;
		krem       = krem_q;

		if (accept && !err_q) begin
			case (phase_q)
				PH_SEQ_TAG: begin
					if (data_byte == TAG_SEQUENCE) begin
						phase_d = PH_SEQ_LEN;
					end else begin
						err = ERR_BAD_TOP_TAG;
					end
				end
				PH_SEQ_LEN: begin
					if ((data_byte & LONG_FORM_MASK) != '0) begin
						err = ERR_LONG_LENGTH;
					end else begin
						seq_d = data_byte[6:0];
						cnt_d = '0;
						if (data_byte[6:0] == '0) begin
							push                 = 1'b1;
							rec.kind             = KIND_EMPTY_SEQ;
							rec.last_of_sequence = 1'b1;
							phase_d              = PH_SEQ_TAG;
						end else begin
							phase_d = PH_INT_TAG;
						end
					end
				end
				PH_INT_TAG: begin
					if (data_byte != TAG_INTEGER) begin
						err = ERR_BAD_INNER_TAG;
					end else begin
						seq_d = seq_q - 7'd1;
						// length byte would sit past the sequence
						if (seq_q == 7'd1) begin
							err = ERR_OVERRUN;
						end else begin
							phase_d = PH_INT_LEN;
						end
					end
				end
				PH_INT_LEN: begin
					if ((data_byte & LONG_FORM_MASK) != '0) begin
						err = ERR_LONG_LENGTH;
					end else begin
						seq_d = seq_q - 7'd1;
						if (data_byte[6:0] > seq_d) begin
							err = ERR_OVERRUN;
						end else if (data_byte[6:0] == '0) begin
							klen_d   = '0;
							do_empty = 1'b1;
						end else begin
							int_d   = data_byte[6:0];
							phase_d = PH_FIRST;
						end
					end
				end
				PH_FIRST: begin
					seq_d = seq_q - 7'd1;
					int_d = int_q - 7'd1;
					// one leading zero byte is dropped
					if (data_byte == '0) begin
						krem_d = int_d;
						klen_d = int_d;
						if (int_d == '0) begin
							do_empty = 1'b1;
						end else begin
							phase_d = PH_CONTENT;
						end
					end else begin
						krem       = int_q;
						klen_d     = int_q;
						phase_d    = PH_CONTENT;
						do_content = 1'b1;
					end
				end
				PH_CONTENT: begin
					seq_d      = seq_q - 7'd1;
					int_d      = int_q - 7'd1;
					do_content = 1'b1;
				end
				default: begin
					phase_d = PH_SEQ_TAG;
				end
			endcase

			if (do_content) begin
				push                 = 1'b1;
				rec.kind             = KIND_CONTENT;
				rec.content_byte     = data_byte;
				rec.byte_position    = krem - 7'd1;
				rec.integer_index    = cnt_q;
				rec.integer_length   = klen_d;
				rec.last_of_integer  = (krem == 7'd1);
				rec.last_of_sequence = (krem == 7'd1) && (seq_d == '0);
				krem_d               = krem - 7'd1;
				finish               = (krem == 7'd1);
			end

			if (do_empty) begin
				push                 = 1'b1;
				rec.kind             = KIND_EMPTY_INT;
				rec.integer_index    = cnt_q;
				rec.last_of_integer  = 1'b1;
				rec.last_of_sequence = (seq_d == '0);
				finish               = 1'b1;
			end

			if (finish) begin
				if (cnt_q != 8'hff) begin
					cnt_d = cnt_q + 8'd1;
				end
				phase_d = (seq_d == '0) ? PH_SEQ_TAG : PH_INT_TAG;
			end

			if (err != ERR_NONE) begin
				push           = 1'b1;
				rec            = '0;
				rec.kind       = KIND_ERROR;
				rec.error_code = err;
				err_d          = 1'b1;
			end

			// buffer ended inside a sequence
			if (last_of_buffer && err == ERR_NONE && phase_d != PH_SEQ_TAG) begin
				push           = 1'b1;
				rec            = '0;
				rec.kind       = KIND_ERROR;
				rec.error_code = ERR_TRUNCATED;
			end
		end

		if (accept && last_of_buffer) begin
			phase_d = PH_SEQ_TAG;
			seq_d   = '0;
			int_d   = '0;
			krem_d  = '0;
			klen_d  = '0;
			cnt_d   = '0;
			err_d   = 1'b0;
		end
	end

	`DERSP_ASSERT_HOLDS(a_content_pending, phase_q == PH_CONTENT, krem_q != '0,
		"content phase with no kept bytes left")
	`DERSP_ASSERT_HOLDS(a_int_within_seq, phase_q == PH_FIRST || phase_q == PH_CONTENT,
		int_q <= seq_q, "integer extends past its sequence")
	`DERSP_ASSERT_NEXT(a_last_restores, accept && last_of_buffer,
		phase_q == PH_SEQ_TAG && !err_q && cnt_q == '0, "last beat did not restore state")
	`DERSP_ASSERT_HOLDS(a_silent_on_error, err_q, !push, "result given while error latched")

endmodule

[rtl/dersp_queue.sv]
// ----------------------------------------------------------------------------
// dersp_queue
// small fifo of classified results between front and back
// ----------------------------------------------------------------------------
`include "der_integer_sequence_parser_defines.svh"

module dersp_queue import dersp_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output rec_t head_rec
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rec_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_rec   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`DERSP_ASSERT_HOLDS(a_no_overflow, push, !full || pop, "push into full queue")
	`DERSP_ASSERT_HOLDS(a_no_underflow, pop, head_valid, "pop from empty queue")
	`DERSP_ASSERT_HOLDS(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "queue count past depth")

endmodule

[rtl/dersp_back.sv]
// ----------------------------------------------------------------------------
// dersp_back
// drains the queue, cleans fields per result kind, holds the output beat
// ----------------------------------------------------------------------------
module dersp_back import dersp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  rec_t       head_rec,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] content_byte,
	output logic [6:0] byte_position,
	output logic [7:0] integer_index,
	output logic [6:0] integer_length,
	output logic       last_of_integer,
	output logic       last_of_sequence,
	output logic [2:0] error_code
);

	logic out_valid_q;
	rec_t out_q;
	rec_t clean;

	assign pop = head_valid && (!out_valid_q || out_ready);

	// fields that do not belong to a kind read as zero
	always_comb begin
		clean      = '0;
		clean.kind = head_rec.kind;
		case (head_rec.kind)
			KIND_CONTENT: begin
				clean                  = head_rec;
				clean.error_code       = ERR_NONE;
			end
			KIND_EMPTY_INT: begin
				clean.integer_index    = head_rec.integer_index;
				clean.last_of_integer  = 1'b1;
				clean.last_of_sequence = head_rec.last_of_sequence;
			end
			KIND_EMPTY_SEQ: begin
				clean.last_of_sequence = 1'b1;
			end
			KIND_ERROR: begin
				clean.error_code       = head_rec.error_code;
			end
			default: begin
				clean = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= clean;
		end
	end

	assign out_valid        = out_valid_q;
	assign kind             = out_q.kind;
	assign content_byte     = out_q.content_byte;
	assign byte_position    = out_q.byte_position;
	assign integer_index    = out_q.integer_index;
	assign integer_length   = out_q.integer_length;
	assign last_of_integer  = out_q.last_of_integer;
	assign last_of_sequence = out_q.last_of_sequence;
	assign error_code       = out_q.error_code;

endmodule

[rtl/der_integer_sequence_parser.sv]
// ----------------------------------------------------------------------------
// der_integer_sequence_parser
// short-form der parser for sequences of integers, one byte per beat
// ----------------------------------------------------------------------------
// Takes one buffer byte per cycle while in_ready is high, and gives at most one
// result beat per byte. A byte is classified by the front in the cycle it is
// accepted; its result is written into a QUEUE_DEPTH entry queue on that same
// edge and moves on into the output register once that register is free or
// being taken, behind any results queued before it.
// in_ready drops only while that queue is full, which happens only when the
// output side stalls. After an error no result is given until the byte marked
// last_of_buffer, which always returns the parser to its reset state.
module der_integer_sequence_parser import dersp_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_of_buffer,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] content_byte,
	output logic [6:0] byte_position,
	output logic [7:0] integer_index,
	output logic [6:0] integer_length,
	output logic       last_of_integer,
	output logic       last_of_sequence,
	output logic [2:0] error_code
);

	logic push;
	rec_t push_rec;
	logic q_full;
	logic pop;
	logic head_valid;
	rec_t head_rec;

	dersp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.last_of_buffer (last_of_buffer),
		.q_full         (q_full),
		.push           (push),
		.rec            (push_rec)
	);

	dersp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (push_rec),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_rec   (head_rec)
	);

	dersp_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head_valid       (head_valid),
		.head_rec         (head_rec),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.kind             (kind),
		.content_byte     (content_byte),
		.byte_position    (byte_position),
		.integer_index    (integer_index),
		.integer_length   (integer_length),
		.last_of_integer  (last_of_integer),
		.last_of_sequence (last_of_sequence),
		.error_code       (error_code)
	);

endmodule
